/* sv/kwm_pkg.sv */
package kwm_pkg;

  // Fixed field widths.
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned REQ_W      = 2;
  localparam int unsigned INDEX_W    = 3;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned CFG_W      = 4;
  // Wide enough to hold any list count up to the largest supported NUM_LISTS.
  localparam int unsigned CNT_W      = 6;

  localparam int unsigned NUM_LISTS_DEF  = 8;
  localparam int unsigned LIST_DEPTH_DEF = 64;
  localparam int unsigned CFG_RESET      = 8;

  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND = 2'd0,
    REQ_POP    = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK     = 3'd0,
    STAT_FULL   = 3'd1,
    STAT_ORDER  = 3'd2,
    STAT_EMPTY  = 3'd3,
    STAT_BADIDX = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_APP_RD,
    S_APP_CMP,
    S_SCAN,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    status_e            status;
    logic               last;
  } result_t;

endpackage

/* sv/kwm_if.sv */
interface kwm_in_if;
  import kwm_pkg::*;

  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic [INDEX_W-1:0] list_index;
  logic [VALUE_W-1:0] value;

  modport source (output valid, req_type, list_index, value, input ready);
  modport sink   (input valid, req_type, list_index, value, output ready);
endinterface

interface kwm_out_if;
  import kwm_pkg::*;

  logic                valid;
  logic                ready;
  logic [VALUE_W-1:0]  merged_value;
  logic [STATUS_W-1:0] status;
  logic                last_element;

  modport source (output valid, merged_value, status, last_element, input ready);
  modport sink   (input valid, merged_value, status, last_element, output ready);
endinterface

interface kwm_cfg_if;
  import kwm_pkg::*;

  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] lists_in_use;

  modport source (output valid, lists_in_use, input ready);
  modport sink   (input valid, lists_in_use, output ready);
endinterface

/* sv/k_way_sorted_merge.sv */
// Channel  Modport  Payload                                  Beat taken when
// in_i     sink     req_type, list_index, value              in_i.valid & in_i.ready
// out_o    source   merged_value, status, last_element       out_o.valid & out_o.ready
// cfg_i    sink     lists_in_use                             cfg_i.valid & cfg_i.ready
//
// After the input beat an append passes through S_APP_RD to S_DONE, by way of S_APP_CMP when the
// tail is fetched for the order check; a refused index, a clear or an unused request goes
// straight to S_DONE. A pop scans in S_SCAN over n, the lists in use after limiting: the
// single comparator walks the list heads one per cycle, fed by the single read port of the
// element memory. S_DONE loads the result into the output register once it is free or read.
// in_i.ready is high only while the sequencer is idle, from the cycle in which a result
// appears; that result may wait in the output register while the next beat is taken.
// Reset empties every list and sets lists_in_use to 8; the memory needs no clearing.
module k_way_sorted_merge #(
  parameter int unsigned NUM_LISTS  = kwm_pkg::NUM_LISTS_DEF,
  parameter int unsigned LIST_DEPTH = kwm_pkg::LIST_DEPTH_DEF
) (
  input logic      clk_i,
  input logic      rst_ni,
  kwm_in_if.sink   in_i,
  kwm_out_if.source out_o,
  kwm_cfg_if.sink  cfg_i
);
  import kwm_pkg::*;

  localparam int unsigned AW = $clog2(NUM_LISTS) + $clog2(LIST_DEPTH);

  logic [CFG_W-1:0] lists_in_use_q;
  logic [CNT_W-1:0] n_eff;
  result_t          res;

  logic               mem_re, mem_we;
  logic [AW-1:0]      mem_raddr, mem_waddr;
  logic [VALUE_W-1:0] mem_wdata, mem_rdata;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lists_in_use_q <= CFG_W'(CFG_RESET);
    end else if (cfg_i.valid) begin
      lists_in_use_q <= cfg_i.lists_in_use;
    end
  end

  // A count of zero acts as one list; a count above NUM_LISTS is capped.
  always_comb begin
    if (lists_in_use_q == '0) begin
      n_eff = CNT_W'(1);
    end else if (CNT_W'(lists_in_use_q) > CNT_W'(NUM_LISTS)) begin
      n_eff = CNT_W'(NUM_LISTS);
    end else begin
      n_eff = CNT_W'(lists_in_use_q);
    end
  end

  kwm_ctrl #(
    .NUM_LISTS  (NUM_LISTS),
    .LIST_DEPTH (LIST_DEPTH),
    .AW         (AW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .n_eff_i     (n_eff),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .req_i       (req_e'(in_i.req_type)),
    .idx_i       (in_i.list_index),
    .val_i       (in_i.value),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .res_o       (res),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata)
  );

  kwm_store #(
    .AW (AW)
  ) u_store (
    .clk_i   (clk_i),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  assign out_o.merged_value = res.value;
  assign out_o.status       = res.status;
  assign out_o.last_element = res.last;

endmodule

/* sv/kwm_store.sv */
module kwm_store #(
  parameter int unsigned AW = 9
) (
  input  logic                        clk_i,
  input  logic                        re_i,
  input  logic [AW-1:0]               raddr_i,
  input  logic                        we_i,
  input  logic [AW-1:0]               waddr_i,
  input  logic [kwm_pkg::VALUE_W-1:0] wdata_i,
  output logic [kwm_pkg::VALUE_W-1:0] rdata_o
);
  import kwm_pkg::*;

  logic [VALUE_W-1:0] mem [2**AW];
  logic [VALUE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/kwm_ctrl.sv */
module kwm_ctrl #(
  parameter int unsigned NUM_LISTS  = kwm_pkg::NUM_LISTS_DEF,
  parameter int unsigned LIST_DEPTH = kwm_pkg::LIST_DEPTH_DEF,
  parameter int unsigned AW         = $clog2(NUM_LISTS) + $clog2(LIST_DEPTH)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [kwm_pkg::CNT_W-1:0]   n_eff_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  kwm_pkg::req_e               req_i,
  input  logic [kwm_pkg::INDEX_W-1:0] idx_i,
  input  logic [kwm_pkg::VALUE_W-1:0] val_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output kwm_pkg::result_t            res_o,
  output logic                        mem_re_o,
  output logic [AW-1:0]               mem_raddr_o,
  output logic                        mem_we_o,
  output logic [AW-1:0]               mem_waddr_o,
  output logic [kwm_pkg::VALUE_W-1:0] mem_wdata_o,
  input  logic [kwm_pkg::VALUE_W-1:0] mem_rdata_i
);
  import kwm_pkg::*;

  localparam int unsigned LW = $clog2(NUM_LISTS);
  localparam int unsigned SW = $clog2(LIST_DEPTH);
  localparam int unsigned PW = $clog2(LIST_DEPTH + 1);

  state_e state_q, state_d;

  logic [PW-1:0] wc_q [NUM_LISTS];
  logic [PW-1:0] rp_q [NUM_LISTS];

  logic [LW-1:0]      idx_q, idx_d;
  logic [VALUE_W-1:0] val_q, val_d;
  logic [CNT_W-1:0]   scan_q, scan_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               pend_q, pend_d;
  logic [LW-1:0]      pend_list_q, pend_list_d;
  logic               pend_last_q, pend_last_d;
  logic               found_q, found_d;
  logic [LW-1:0]      best_q, best_d;
  logic [VALUE_W-1:0] best_val_q, best_val_d;
  logic               best_last_q, best_last_d;
  result_t            fin_q, fin_d;
  result_t            res_q, res_d;
  logic               out_valid_q, out_valid_d;

  // Counter access goes through one list index per cycle.
  logic [LW-1:0] cur_list;
  logic [PW-1:0] cur_wc, cur_rp;
  logic          wc_inc, rp_inc, clr_all;

  // The one shared signed comparator.
  logic [VALUE_W-1:0] cmp_a, cmp_b;
  logic               cmp_lt;

  logic scan_live;

  assign scan_live = (scan_q < n_eff_i);

  always_comb begin
    if (state_q == S_APP_RD || state_q == S_APP_CMP) begin
      cur_list = idx_q;
    end else if (state_q == S_SCAN && scan_live) begin
      cur_list = LW'(scan_q);
    end else begin
      cur_list = best_q;
    end
  end

  assign cur_wc = wc_q[cur_list];
  assign cur_rp = rp_q[cur_list];

  assign cmp_a  = (state_q == S_APP_CMP) ? val_q : mem_rdata_i;
  assign cmp_b  = (state_q == S_APP_CMP) ? mem_rdata_i : best_val_q;
  assign cmp_lt = ($signed(cmp_a) < $signed(cmp_b));

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    val_d       = val_q;
    scan_d      = scan_q;
    cnt_d       = cnt_q;
    pend_d      = 1'b0;
    pend_list_d = pend_list_q;
    pend_last_d = pend_last_q;
    found_d     = found_q;
    best_d      = best_q;
    best_val_d  = best_val_q;
    best_last_d = best_last_q;
    fin_d       = fin_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    wc_inc      = 1'b0;
    rp_inc      = 1'b0;
    clr_all     = 1'b0;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;
    mem_we_o    = 1'b0;
    mem_waddr_o = {cur_list, SW'(cur_wc)};
    mem_wdata_o = val_q;
    in_ready_o  = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        fin_d      = '{value: '0, status: STAT_OK, last: 1'b0};
        if (in_valid_i) begin
          idx_d = LW'(idx_i);
          val_d = val_i;
          case (req_i)
            REQ_APPEND: begin
              if (CNT_W'(idx_i) >= n_eff_i) begin
                fin_d.status = STAT_BADIDX;
                state_d      = S_DONE;
              end else begin
                state_d = S_APP_RD;
              end
            end
            REQ_POP: begin
              scan_d  = '0;
              cnt_d   = '0;
              found_d = 1'b0;
              state_d = S_SCAN;
            end
            REQ_CLEAR: begin
              clr_all = 1'b1;
              state_d = S_DONE;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_APP_RD: begin
        if (cur_wc == PW'(LIST_DEPTH)) begin
          fin_d.status = STAT_FULL;
          state_d      = S_DONE;
        end else if (cur_rp < cur_wc) begin
          // Fetch the tail to check ordering.
          mem_re_o    = 1'b1;
          mem_raddr_o = {cur_list, SW'(cur_wc - 1'b1)};
          state_d     = S_APP_CMP;
        end else begin
          mem_we_o = 1'b1;
          wc_inc   = 1'b1;
          state_d  = S_DONE;
        end
      end

      S_APP_CMP: begin
        if (cmp_lt) begin
          fin_d.status = STAT_ORDER;
        end else begin
          mem_we_o = 1'b1;
          wc_inc   = 1'b1;
        end
        state_d = S_DONE;
      end

      S_SCAN: begin
        // Issue the head read for one list while the previous head is compared.
        if (scan_live) begin
          scan_d = scan_q + 1'b1;
          if (cur_rp < cur_wc) begin
            mem_re_o    = 1'b1;
            mem_raddr_o = {cur_list, SW'(cur_rp)};
            pend_d      = 1'b1;
            pend_list_d = cur_list;
            pend_last_d = (PW'(cur_rp + 1'b1) == cur_wc);
          end
        end
        if (pend_q) begin
          cnt_d = cnt_q + 1'b1;
          if (!found_q || cmp_lt) begin
            found_d     = 1'b1;
            best_d      = pend_list_q;
            best_val_d  = mem_rdata_i;
            best_last_d = pend_last_q;
          end
        end
        if (!scan_live && !pend_q) begin
          if (!found_q) begin
            fin_d.status = STAT_EMPTY;
          end else begin
            rp_inc      = 1'b1;
            fin_d.value = best_val_q;
            fin_d.last  = (cnt_q == CNT_W'(1)) && best_last_q;
          end
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          res_d       = fin_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
      found_q     <= 1'b0;
      scan_q      <= '0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
      found_q     <= found_d;
      scan_q      <= scan_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    val_q       <= val_d;
    pend_list_q <= pend_list_d;
    pend_last_q <= pend_last_d;
    best_q      <= best_d;
    best_val_q  <= best_val_d;
    best_last_q <= best_last_d;
    fin_q       <= fin_d;
    res_q       <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_LISTS; i++) begin
        wc_q[i] <= '0;
        rp_q[i] <= '0;
      end
    end else if (clr_all) begin
      for (int i = 0; i < NUM_LISTS; i++) begin
        wc_q[i] <= '0;
        rp_q[i] <= '0;
      end
    end else begin
      if (wc_inc) begin
        wc_q[cur_list] <= cur_wc + 1'b1;
      end
      if (rp_inc) begin
        rp_q[cur_list] <= cur_rp + 1'b1;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

/* sv/kwm_checker.sv */
module kwm_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [kwm_pkg::VALUE_W-1:0]  merged_value,
  input logic [kwm_pkg::STATUS_W-1:0] status,
  input logic                         last_element
);
  import kwm_pkg::*;

  // Once an item is taken, in_ready drops; two items are never taken back to back.
  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken on consecutive cycles");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(merged_value) && $stable(status))
    else $error("stalled result changed");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (status != STAT_OK) |-> (merged_value == '0) && !last_element)
    else $error("flagged result carries data");

  a_last_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && last_element |-> (status == STAT_OK))
    else $error("last element on a failed result");

endmodule

bind k_way_sorted_merge kwm_checker u_kwm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid     (in_i.valid),
  .in_ready     (in_i.ready),
  .out_valid    (out_o.valid),
  .out_ready    (out_o.ready),
  .merged_value (out_o.merged_value),
  .status       (out_o.status),
  .last_element (out_o.last_element)
);
